>>> rtl/jfsp_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the JPEG frame size parser modules.
// No dependencies.
package jfsp_pkg;

    // Marker and byte codes
    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] CODE_SOI = 8'hD8;
    localparam logic [7:0] CODE_EOI = 8'hD9;
    localparam logic [7:0] CODE_SOS = 8'hDA;
    localparam logic [7:0] CODE_SOF_FIRST = 8'hC0;
    localparam logic [7:0] CODE_SOF_LAST  = 8'hC3;

    // Positions inside a frame header
    localparam logic [2:0] FRM_HEIGHT_HI = 3'd3;
    localparam logic [2:0] FRM_HEIGHT_LO = 3'd4;
    localparam logic [2:0] FRM_WIDTH_HI  = 3'd5;
    localparam logic [2:0] FRM_WIDTH_LO  = 3'd6;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [3:0] {
        PH_SOI_FF = 4'd0,
        PH_SOI_D8 = 4'd1,
        PH_HUNT   = 4'd2,
        PH_CODE   = 4'd3,
        PH_LEN_HI = 4'd4,
        PH_LEN_LO = 4'd5,
        PH_SKIP   = 4'd6,
        PH_FRAME  = 4'd7,
        PH_DONE   = 4'd8
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic        status;
        logic [15:0] width;
        logic [15:0] height;
    } out_item_t;

    // Classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
        logic       is_ff;
        logic       is_soi;
        logic       is_stop;
        logic       is_sof;
    } byte_class_t;

endpackage

>>> rtl/jfsp_front.sv
`timescale 1ns / 1ps
// Front end: accepts byte transactions and classifies each byte by marker code.
// Depends on jfsp_pkg.
module jfsp_front (
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  jfsp_pkg::in_item_t    byte_item,
    input  logic                  q_full,
    output logic                  q_push,
    output jfsp_pkg::byte_class_t q_entry
);
    import jfsp_pkg::*;

    // Accept whenever the queue has room
    assign byte_ready = !q_full;
    assign q_push     = byte_valid && !q_full;

    // Decode the marker classes once, ahead of the parser
    always_comb
    begin
        q_entry.data_byte     = byte_item.data_byte;
        q_entry.end_of_stream = byte_item.end_of_stream;
        q_entry.is_ff         = (byte_item.data_byte == BYTE_FF);
        q_entry.is_soi        = (byte_item.data_byte == CODE_SOI);
        q_entry.is_stop       = (byte_item.data_byte == CODE_EOI) ||
                                (byte_item.data_byte == CODE_SOS);
        q_entry.is_sof        = (byte_item.data_byte >= CODE_SOF_FIRST) &&
                                (byte_item.data_byte <= CODE_SOF_LAST);
    end

endmodule

>>> rtl/jfsp_queue.sv
`timescale 1ns / 1ps
// Small FIFO between the classifier and the parser; push and pop may happen in the same cycle.
// Depends on jfsp_pkg.
module jfsp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  jfsp_pkg::byte_class_t push_entry,
    input  logic                  pop,
    output logic                  q_valid,
    output logic                  q_full,
    output jfsp_pkg::byte_class_t head
);
    import jfsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    byte_class_t         slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == FULL_CNT);
    assign head    = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry; slots need no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/jfsp_back.sv
`timescale 1ns / 1ps
// Back end: marker-walking parser state machine and the result register.
// Depends on jfsp_pkg.
module jfsp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  jfsp_pkg::byte_class_t head,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_ready,
    output jfsp_pkg::out_item_t   result_item
);
    import jfsp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] skip_reg, skip_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [2:0]  frm_idx_reg, frm_idx_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  width_hi_reg, width_hi_next;
    logic        res_valid_reg, res_valid_next;
    out_item_t   res_reg, res_next;

    logic        emit;
    logic        emit_ok;
    logic [15:0] seg_len;

    // Take the next transaction when the result slot is free or draining
    assign pop          = q_valid && (!res_valid_reg || result_ready);
    assign result_valid = res_valid_reg;
    assign result_item  = res_reg;
    assign seg_len      = {len_hi_reg, head.data_byte};

    // Next state and verdict
    always_comb
    begin
        phase_next    = phase_reg;
        skip_next     = skip_reg;
        len_hi_next   = len_hi_reg;
        frm_idx_next  = frm_idx_reg;
        height_next   = height_reg;
        width_hi_next = width_hi_reg;
        emit          = 1'b0;
        emit_ok       = 1'b0;

        if (pop)
        begin
            if (head.end_of_stream)
            begin
                // Re-arm; fail if no verdict yet
                emit          = (phase_reg < PH_DONE);
                phase_next    = PH_SOI_FF;
                skip_next     = '0;
                len_hi_next   = '0;
                frm_idx_next  = '0;
                height_next   = '0;
                width_hi_next = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_SOI_FF:
                    begin
                        if (head.is_ff)
                        begin
                            phase_next = PH_SOI_D8;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    PH_SOI_D8:
                    begin
                        if (head.is_soi)
                        begin
                            phase_next = PH_HUNT;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    PH_HUNT:
                    begin
                        if (head.is_ff)
                        begin
                            phase_next = PH_CODE;
                        end
                    end
                    PH_CODE:
                    begin
                        if (head.is_ff)
                        begin
                            phase_next = PH_CODE;
                        end
                        else if (head.is_stop)
                        begin
                            emit = 1'b1;
                        end
                        else if (head.is_sof)
                        begin
                            frm_idx_next = '0;
                            phase_next   = PH_FRAME;
                        end
                        else
                        begin
                            phase_next = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI:
                    begin
                        len_hi_next = head.data_byte;
                        phase_next  = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        if (seg_len < 16'd2)
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            skip_next  = seg_len - 16'd2;
                            phase_next = (seg_len == 16'd2) ? PH_HUNT : PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_reg - 16'd1;
                        if (skip_reg == 16'd1)
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    PH_FRAME:
                    begin
                        frm_idx_next = frm_idx_reg + 3'd1;
                        case (frm_idx_reg)
                            FRM_HEIGHT_HI: height_next   = {head.data_byte, 8'h00};
                            FRM_HEIGHT_LO: height_next   = {height_reg[15:8], head.data_byte};
                            FRM_WIDTH_HI:  width_hi_next = head.data_byte;
                            FRM_WIDTH_LO:
                            begin
                                emit         = 1'b1;
                                emit_ok      = 1'b1;
                                frm_idx_next = frm_idx_reg;
                            end
                            default:
                            begin
                                height_next = height_reg;
                            end
                        endcase
                    end
                    default:
                    begin
                        // Verdict given: drop bytes until end of stream
                        phase_next = phase_reg;
                    end
                endcase
                if (emit)
                begin
                    phase_next = PH_DONE;
                end
            end
        end

        // Result register: load on a verdict, clear when taken
        res_next = res_reg;
        if (emit)
        begin
            res_valid_next = 1'b1;
            if (emit_ok)
            begin
                res_next.status = STATUS_OK;
                res_next.width  = {width_hi_reg, head.data_byte};
                res_next.height = height_reg;
            end
            else
            begin
                res_next.status = STATUS_FAIL;
                res_next.width  = '0;
                res_next.height = '0;
            end
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SOI_FF;
            skip_reg      <= '0;
            len_hi_reg    <= '0;
            frm_idx_reg   <= '0;
            height_reg    <= '0;
            width_hi_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            len_hi_reg    <= len_hi_next;
            frm_idx_reg   <= frm_idx_next;
            height_reg    <= height_next;
            width_hi_reg  <= width_hi_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload holds until reloaded
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

>>> rtl/jpeg_frame_size_parser_core.sv
`timescale 1ns / 1ps
// JPEG frame size parser: takes a JPEG file one byte per transaction and returns
// one result per file: status 0 with width and height from the first SOF0..SOF3
// frame header, or status 1 with zero dimensions for a bad start, an SOS or EOI
// marker, a segment length below 2, or end of stream before a verdict. An item
// with end_of_stream set carries no byte and re-arms the block for the next file.
// One byte is taken every clock cycle while the queue has room; the parser state
// machine updates once per byte and is the only loop. A byte passes the classifier
// and a QUEUE_DEPTH-entry queue; a result is loaded into the output register when
// the byte that decides it is popped from the queue. While a result waits there the
// parser holds, the queue takes up to QUEUE_DEPTH more bytes and then the input stalls.
// Depends on jfsp_pkg, jfsp_front, jfsp_queue, jfsp_back.
module jpeg_frame_size_parser_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  jfsp_pkg::in_item_t  byte_item,
    output logic                result_valid,
    input  logic                result_ready,
    output jfsp_pkg::out_item_t result_item
);
    import jfsp_pkg::*;

    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_valid;
    byte_class_t q_entry;
    byte_class_t q_head;

    // Classify incoming bytes
    jfsp_front u_front (
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    // Decouple classifier from parser
    jfsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_full     (q_full),
        .head       (q_head)
    );

    // Walk markers and report dimensions
    jfsp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .head         (q_head),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

>>> sim/tb_jpeg_frame_size_parser_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for jpeg_frame_size_parser_core: feeds JPEG byte streams,
// predicts each file's dimension or failure verdict and compares every result.
// Depends on jfsp_pkg and the jpeg_frame_size_parser_core RTL.
module tb_jpeg_frame_size_parser_core;
    import jfsp_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 800;

    // Track the expected verdict of every file and check delivered results
    class frame_size_board;
        out_item_t   verdicts_due[$];
        phase_t      phase;
        logic [15:0] skip_left;
        logic [7:0]  len_hi;
        logic [2:0]  frame_pos;
        logic [15:0] height_acc;
        logic [7:0]  width_hi;
        int unsigned errors;
        int unsigned ok_count;
        int unsigned fail_count;
        int unsigned bytes_seen;

        function new();
            errors     = 0;
            ok_count   = 0;
            fail_count = 0;
            bytes_seen = 0;
            rearm();
        endfunction

        function void rearm();
            phase      = PH_SOI_FF;
            skip_left  = '0;
            len_hi     = '0;
            frame_pos  = '0;
            height_acc = '0;
            width_hi   = '0;
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        // Queue one verdict and close the file
        function void post_verdict(logic st, logic [15:0] w, logic [15:0] h);
            out_item_t v;
            v.status = st;
            v.width  = w;
            v.height = h;
            verdicts_due.push_back(v);
            phase = PH_DONE;
        endfunction

        // Advance the scan by one accepted transaction
        function void note_byte(in_item_t it);
            logic [7:0]  b;
            logic [15:0] seg_len;
            b = it.data_byte;
            bytes_seen++;
            if (it.end_of_stream)
            begin
                if (phase != PH_DONE)
                    post_verdict(STATUS_FAIL, '0, '0);
                rearm();
                return;
            end
            case (phase)
                PH_SOI_FF:
                begin
                    if (b != BYTE_FF) post_verdict(STATUS_FAIL, '0, '0);
                    else phase = PH_SOI_D8;
                end
                PH_SOI_D8:
                begin
                    if (b != CODE_SOI) post_verdict(STATUS_FAIL, '0, '0);
                    else phase = PH_HUNT;
                end
                PH_HUNT:
                begin
                    if (b == BYTE_FF) phase = PH_CODE;
                end
                PH_CODE:
                begin
                    // Swallow fill bytes, stop on EOI or SOS
                    if (b == BYTE_FF)
                    begin
                        phase = PH_CODE;
                    end
                    else if (b == CODE_EOI || b == CODE_SOS)
                    begin
                        post_verdict(STATUS_FAIL, '0, '0);
                    end
                    else if (b >= CODE_SOF_FIRST && b <= CODE_SOF_LAST)
                    begin
                        frame_pos = '0;
                        phase     = PH_FRAME;
                    end
                    else
                    begin
                        phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    len_hi = b;
                    phase  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    seg_len = {len_hi, b};
                    if (seg_len < 16'd2)
                    begin
                        post_verdict(STATUS_FAIL, '0, '0);
                    end
                    else
                    begin
                        skip_left = seg_len - 16'd2;
                        phase     = (skip_left == 16'd0) ? PH_HUNT : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 16'd0) phase = PH_HUNT;
                end
                PH_FRAME:
                begin
                    if (frame_pos == FRM_WIDTH_LO)
                    begin
                        post_verdict(STATUS_OK, {width_hi, b}, height_acc);
                    end
                    else
                    begin
                        case (frame_pos)
                            FRM_HEIGHT_HI: height_acc = {b, 8'h00};
                            FRM_HEIGHT_LO: height_acc[7:0] = b;
                            FRM_WIDTH_HI:  width_hi = b;
                            default: ;
                        endcase
                        frame_pos = frame_pos + 3'd1;
                    end
                end
                default: ;
            endcase
        endfunction

        // Compare a delivered result with the oldest verdict due
        function void check_verdict(out_item_t got);
            out_item_t want;
            if (verdicts_due.size() == 0)
            begin
                $error("result with no verdict due: status %0d width %0d height %0d",
                       got.status, got.width, got.height);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got.status !== want.status)
            begin
                $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.width !== want.width)
            begin
                $error("width mismatch: expected %0d, got %0d", want.width, got.width);
                errors++;
            end
            if (got.height !== want.height)
            begin
                $error("height mismatch: expected %0d, got %0d", want.height, got.height);
                errors++;
            end
            if (want.status == STATUS_OK) ok_count++;
            else fail_count++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_ready;
    in_item_t    byte_item;
    logic        result_valid;
    logic        result_ready;
    out_item_t   result_item;

    frame_size_board board;
    in_item_t        file_bytes[$];
    int              send_idle_pct;
    int              recv_idle_pct;
    logic            hold_window;
    bit              hold_done;
    int unsigned     cycle_count;
    int unsigned     live_items;
    int unsigned     files_sent;

    jpeg_frame_size_parser_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Observe both handshakes on the rising edge
    always @(posedge clk)
    begin
        if (rst_n && byte_valid && byte_ready)
            board.note_byte(byte_item);
        if (rst_n && result_valid && result_ready)
            board.check_verdict(result_item);
    end

    // Drive result_ready; stall once for a long stretch when asked
    initial
    begin
        hold_done = 1'b0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_window && !hold_done)
            begin
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("jpeg_frame_size_parser_core verification failed");
        $finish;
    end

    function void add_byte(logic [7:0] b);
        in_item_t t;
        t.data_byte     = b;
        t.end_of_stream = 1'b0;
        file_bytes.push_back(t);
    endfunction

    function void add_eos();
        in_item_t t;
        t.data_byte     = 8'($urandom_range(0, 255));
        t.end_of_stream = 1'b1;
        file_bytes.push_back(t);
    endfunction

    function void add_soi();
        add_byte(BYTE_FF);
        add_byte(CODE_SOI);
    endfunction

    // Marker segment with its length field and random payload
    function void add_segment(logic [7:0] code, logic [15:0] len);
        add_byte(BYTE_FF);
        add_byte(code);
        add_byte(len[15:8]);
        add_byte(len[7:0]);
        if (len > 16'd2)
            repeat (int'(len) - 2) add_byte(8'($urandom_range(0, 255)));
    endfunction

    // Frame header up to and including the width field
    function void add_frame(logic [7:0] code, logic [15:0] h, logic [15:0] w);
        add_byte(BYTE_FF);
        add_byte(code);
        add_byte(8'($urandom_range(0, 255)));
        add_byte(8'($urandom_range(0, 255)));
        add_byte(8'($urandom_range(0, 255)));
        add_byte(h[15:8]);
        add_byte(h[7:0]);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
    endfunction

    function logic [15:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 16'h0000;
        if (r < 16) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    function logic [7:0] pick_segment_code();
        logic [7:0] code;
        do
            code = 8'($urandom_range(0, 255));
        while (code == BYTE_FF || code == CODE_EOI || code == CODE_SOS ||
               (code >= CODE_SOF_FIRST && code <= CODE_SOF_LAST));
        return code;
    endfunction

    // Offer one transaction, idling first at the current rate
    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        @(posedge clk);
        while (!byte_ready) @(posedge clk);
    endtask

    task automatic send_file();
        foreach (file_bytes[i]) send_item(file_bytes[i]);
        file_bytes.delete();
        files_sent++;
    endtask

    // Drop valid and hold until every verdict has come back
    task automatic wait_all_delivered();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    task automatic run_directed();
        // Smallest dimensions with SOF0
        add_soi();
        add_frame(CODE_SOF_FIRST, 16'h0000, 16'h0000);
        add_eos();
        send_file();
        // Largest dimensions with SOF3, trailing bytes and a repeated end of stream
        add_soi();
        add_frame(CODE_SOF_LAST, 16'hFFFF, 16'hFFFF);
        add_byte(BYTE_FF);
        add_byte(CODE_EOI);
        add_byte(8'h00);
        add_eos();
        add_eos();
        send_file();
        // Garbage between markers, fill bytes, empty and short segments, SOF1
        add_soi();
        add_byte(8'h00);
        add_byte(8'h7E);
        add_byte(BYTE_FF);
        add_byte(BYTE_FF);
        add_segment(8'hE0, 16'd2);
        add_segment(8'hFE, 16'd16);
        add_segment(8'h00, 16'd3);
        add_segment(8'hBF, 16'd2);
        add_frame(CODE_SOF_FIRST + 8'd1, 16'h1234, 16'h8001);
        add_eos();
        send_file();
        // Longest possible segment, the code just past SOF3, cut by end of stream
        add_soi();
        add_byte(BYTE_FF);
        add_byte(8'hC4);
        add_byte(8'hFF);
        add_byte(8'hFF);
        add_byte(BYTE_FF);
        add_byte(CODE_SOF_FIRST);
        add_byte(BYTE_FF);
        add_byte(CODE_EOI);
        add_eos();
        send_file();
        // SOF2 with mixed byte halves
        add_soi();
        add_frame(CODE_SOF_FIRST + 8'd2, 16'h00FF, 16'hFF00);
        add_eos();
        send_file();
        // Bad first byte
        add_byte(8'h00);
        add_byte(BYTE_FF);
        add_eos();
        send_file();
        add_byte(CODE_SOI);
        add_eos();
        send_file();
        // Bad second byte
        add_byte(BYTE_FF);
        add_byte(8'h00);
        add_eos();
        send_file();
        add_byte(BYTE_FF);
        add_byte(BYTE_FF);
        add_eos();
        send_file();
        // EOI and SOS before any frame header
        add_soi();
        add_byte(BYTE_FF);
        add_byte(CODE_EOI);
        add_eos();
        send_file();
        add_soi();
        add_segment(8'hE1, 16'd5);
        add_byte(BYTE_FF);
        add_byte(CODE_SOS);
        add_eos();
        send_file();
        // Segment lengths below two
        add_soi();
        add_segment(8'hE0, 16'd0);
        add_eos();
        send_file();
        add_soi();
        add_segment(8'hDB, 16'd1);
        add_eos();
        send_file();
        // Empty file and header only
        add_eos();
        send_file();
        add_soi();
        add_eos();
        send_file();
        // Streams cut inside the frame header, a skip, a marker and a length
        add_soi();
        add_byte(BYTE_FF);
        add_byte(CODE_SOF_FIRST);
        add_byte(8'h00);
        add_byte(8'h11);
        add_byte(8'h08);
        add_byte(8'h01);
        add_eos();
        send_file();
        add_soi();
        add_byte(BYTE_FF);
        add_byte(8'hE0);
        add_byte(8'h00);
        add_byte(8'h10);
        add_byte(8'h01);
        add_byte(8'h02);
        add_eos();
        send_file();
        add_soi();
        add_byte(BYTE_FF);
        add_eos();
        send_file();
        add_soi();
        add_byte(BYTE_FF);
        add_byte(8'hE0);
        add_byte(8'h00);
        add_eos();
        send_file();
    endtask

    task automatic build_random_file();
        int          kind;
        int          cut;
        logic [15:0] len;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            // Well-formed file with random content, sometimes cut short
            add_soi();
            repeat ($urandom_range(0, 3))
            begin
                if ($urandom_range(99) < 30)
                    repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 254)));
                repeat ($urandom_range(0, 2)) add_byte(BYTE_FF);
                if ($urandom_range(99) < 90) len = 16'($urandom_range(2, 12));
                else len = 16'($urandom_range(13, 300));
                add_segment(pick_segment_code(), len);
            end
            add_frame(CODE_SOF_FIRST + 8'($urandom_range(0, 3)), pick_dim(), pick_dim());
            if ($urandom_range(99) < 15)
            begin
                cut = $urandom_range(1, file_bytes.size() - 1);
                while (file_bytes.size() > cut) void'(file_bytes.pop_back());
                live_items += file_bytes.size();
            end
            else
            begin
                live_items += file_bytes.size();
                repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
            end
            add_eos();
        end
        else if (kind < 85)
        begin
            // Noise, rich in marker bytes
            if ($urandom_range(1)) add_soi();
            repeat ($urandom_range(1, 10))
                add_byte($urandom_range(1) ? BYTE_FF : 8'($urandom_range(0, 255)));
            live_items += file_bytes.size();
            add_eos();
        end
        else if (kind < 95)
        begin
            // Broken sequences
            add_soi();
            if ($urandom_range(1))
                add_segment(pick_segment_code(), 16'($urandom_range(2, 8)));
            case ($urandom_range(0, 3))
                0:
                begin
                    add_byte(BYTE_FF);
                    add_byte(CODE_EOI);
                end
                1:
                begin
                    add_byte(BYTE_FF);
                    add_byte(CODE_SOS);
                end
                2: add_segment(pick_segment_code(), 16'($urandom_range(0, 1)));
                default:
                begin
                    file_bytes.delete();
                    add_byte(BYTE_FF);
                    add_byte($urandom_range(0, 1) ? BYTE_FF : 8'($urandom_range(0, 'hD7)));
                end
            endcase
            live_items += file_bytes.size();
            add_eos();
        end
        else
        begin
            // Empty files, back to back end of stream
            add_eos();
            if ($urandom_range(1)) add_eos();
            live_items += 1;
        end
    endtask

    initial
    begin
        board = new();
        rst_n       <= 1'b0;
        byte_valid  <= 1'b0;
        byte_item   <= '0;
        hold_window <= 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 65;
        files_sent    = 0;
        live_items    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Stall the receiver while short failing files keep coming
        hold_window <= 1'b1;
        repeat (40)
        begin
            add_byte(8'($urandom_range(0, 254)));
            add_eos();
            send_file();
        end
        wait_all_delivered();

        // Random files under three idle patterns
        live_items = 0;
        while (live_items < RANDOM_ITEMS / 3)
        begin
            build_random_file();
            send_file();
        end
        send_idle_pct = 65;
        recv_idle_pct = 33;
        while (live_items < 2 * RANDOM_ITEMS / 3)
        begin
            build_random_file();
            send_file();
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            build_random_file();
            send_file();
        end

        wait_all_delivered();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d files, %0d transactions accepted, including a %0d-cycle output stall",
                 files_sent, board.bytes_seen, LONG_HOLD);
        $display("Verdicts checked: %0d dimension reports, %0d failure reports",
                 board.ok_count, board.fail_count);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("jpeg_frame_size_parser_core verification clean");
        end
        else
        begin
            if (board.pending() != 0)
                $error("%0d verdicts never delivered", board.pending());
            $display("jpeg_frame_size_parser_core verification failed");
        end
        $finish;
    end

endmodule
